// ----- rtl/core/kerr_pkg.sv -----
// Key event rollover report: shared constants, types and keymap ROMs.
// No dependencies; every other file of the block uses this package.

package kerr_pkg;

    localparam int SLOT_COUNT = 6;
    localparam int CODE_LIMIT = 70;
    localparam int MAP_SIZE   = 70;
    localparam int OUT_CHARS  = 6;

    localparam int EVENT_W    = 8;
    localparam int CODE_W     = 7;
    localparam int CHAR_W     = 7;
    localparam int MAP_IDX_W  = $clog2(MAP_SIZE);
    localparam int CHAR_CNT_W = $clog2(OUT_CHARS + 1);
    localparam int OUT_IDX_W  = (OUT_CHARS > 1) ? $clog2(OUT_CHARS) : 1;

    // Event byte layout
    localparam int PRESS_BIT = 7;

    // Modifier key codes
    localparam logic [CODE_W-1:0] K_FN    = 7'd3;
    localparam logic [CODE_W-1:0] K_CTRL  = 7'd4;
    localparam logic [CODE_W-1:0] K_SHIFT = 7'd7;
    localparam logic [CODE_W-1:0] K_OPT   = 7'd8;
    localparam logic [CODE_W-1:0] K_ALT   = 7'd14;

    typedef logic [SLOT_COUNT-1:0][CODE_W-1:0] slots_t;

    typedef struct packed {
        logic                            fn_layer;
        logic [OUT_CHARS-1:0][CHAR_W-1:0] chars;
        logic                            any_held;
    } report_t;

    typedef struct packed {
        slots_t slots;
        logic   changed;
    } slot_upd_t;

    localparam logic [CHAR_W-1:0] BASE_MAP [0:MAP_SIZE-1] = '{
        7'h60, 7'h09, 7'h00, 7'h00, 7'h31, 7'h71, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h32, 7'h77, 7'h61, 7'h00, 7'h33, 7'h65, 7'h73, 7'h7A, 7'h00, 7'h00,
        7'h34, 7'h72, 7'h64, 7'h78, 7'h35, 7'h74, 7'h66, 7'h63, 7'h00, 7'h00,
        7'h36, 7'h79, 7'h67, 7'h76, 7'h37, 7'h75, 7'h68, 7'h62, 7'h00, 7'h00,
        7'h38, 7'h69, 7'h6A, 7'h6E, 7'h39, 7'h6F, 7'h6B, 7'h6D, 7'h00, 7'h00,
        7'h30, 7'h70, 7'h6C, 7'h2C, 7'h2D, 7'h5B, 7'h3B, 7'h2E, 7'h00, 7'h00,
        7'h3D, 7'h5D, 7'h27, 7'h2F, 7'h7F, 7'h5C, 7'h0A, 7'h20, 7'h00, 7'h00
    };

    localparam logic [CHAR_W-1:0] UPPER_MAP [0:MAP_SIZE-1] = '{
        7'h7E, 7'h09, 7'h00, 7'h00, 7'h21, 7'h51, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h40, 7'h57, 7'h41, 7'h00, 7'h23, 7'h45, 7'h53, 7'h5A, 7'h00, 7'h00,
        7'h24, 7'h52, 7'h44, 7'h58, 7'h25, 7'h54, 7'h46, 7'h43, 7'h00, 7'h00,
        7'h5E, 7'h59, 7'h47, 7'h56, 7'h26, 7'h55, 7'h48, 7'h42, 7'h00, 7'h00,
        7'h2A, 7'h49, 7'h4A, 7'h4E, 7'h28, 7'h4F, 7'h4B, 7'h4D, 7'h00, 7'h00,
        7'h29, 7'h50, 7'h4C, 7'h3C, 7'h5F, 7'h7B, 7'h3A, 7'h3E, 7'h00, 7'h00,
        7'h2B, 7'h7D, 7'h22, 7'h3F, 7'h7F, 7'h7C, 7'h0A, 7'h20, 7'h00, 7'h00
    };

    function automatic logic is_modifier(input logic [CODE_W-1:0] code);
        return (code == K_FN) || (code == K_SHIFT) || (code == K_CTRL) ||
               (code == K_ALT) || (code == K_OPT);
    endfunction

    // One-based code to character; codes off the end of the map give 0.
    function automatic logic [CHAR_W-1:0] key_char(input logic upper,
                                                   input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0]    idx;
        logic [CHAR_W-1:0]    ch;
        idx = code - CODE_W'(1);
        ch  = '0;
        if ((code != '0) && (idx < CODE_W'(MAP_SIZE)))
        begin
            if (upper)
            begin
                ch = UPPER_MAP[idx[MAP_IDX_W-1:0]];
            end
            else
            begin
                ch = BASE_MAP[idx[MAP_IDX_W-1:0]];
            end
        end
        return ch;
    endfunction

endpackage

// ----- rtl/core/kerr_if.sv -----
// Event and report handshake channels of the key event rollover report block.
// Depends on kerr_pkg for field widths.

interface kerr_event_if;
    logic                         valid;
    logic                         ready;
    logic [kerr_pkg::EVENT_W-1:0] event_byte;

    modport source (output valid, output event_byte, input ready);
    modport sink   (input valid, input event_byte, output ready);
endinterface

interface kerr_report_if;
    logic                        valid;
    logic                        ready;
    logic                        fn_layer;
    logic [kerr_pkg::CHAR_W-1:0] char_0;
    logic [kerr_pkg::CHAR_W-1:0] char_1;
    logic [kerr_pkg::CHAR_W-1:0] char_2;
    logic [kerr_pkg::CHAR_W-1:0] char_3;
    logic [kerr_pkg::CHAR_W-1:0] char_4;
    logic [kerr_pkg::CHAR_W-1:0] char_5;
    logic                        any_held;
    logic                        changed;

    modport source (output valid, output fn_layer, output char_0, output char_1,
                    output char_2, output char_3, output char_4, output char_5,
                    output any_held, output changed, input ready);
    modport sink   (input valid, input fn_layer, input char_0, input char_1,
                    input char_2, input char_3, input char_4, input char_5,
                    input any_held, input changed, output ready);
endinterface

// ----- rtl/core/kerr_slot_update.sv -----
// Held-key slot table update for one key event.
// Depends on kerr_pkg.

module kerr_slot_update
(
    input  logic [kerr_pkg::EVENT_W-1:0] event_byte,
    input  kerr_pkg::slots_t             slots,
    output kerr_pkg::slot_upd_t          upd
);

    logic [kerr_pkg::CODE_W-1:0] code;
    logic                        press;
    logic                        code_ok;
    logic                        held;
    logic                        done;

    always_comb
    begin
        code    = event_byte[kerr_pkg::CODE_W-1:0];
        press   = event_byte[kerr_pkg::PRESS_BIT];
        code_ok = (code != '0) && (code <= kerr_pkg::CODE_W'(kerr_pkg::CODE_LIMIT));
        held    = 1'b0;
        done    = 1'b0;
        upd.slots   = slots;
        upd.changed = code_ok;

        for (int i = 0; i < kerr_pkg::SLOT_COUNT; i++)
        begin
            if (slots[i] == code)
            begin
                held = 1'b1;
            end
        end

        if (code_ok)
        begin
            for (int i = 0; i < kerr_pkg::SLOT_COUNT; i++)
            begin
                if (press)
                begin
                    // first empty slot, only if not already held
                    if (!held && !done && (slots[i] == '0))
                    begin
                        upd.slots[i] = code;
                        done = 1'b1;
                    end
                end
                else if (!done && (slots[i] == code))
                begin
                    upd.slots[i] = '0;
                    done = 1'b1;
                end
            end
        end
    end

endmodule

// ----- rtl/core/kerr_report.sv -----
// Report builder: layer flag, keymap lookup and slot-order character packing.
// Depends on kerr_pkg.

module kerr_report
(
    input  kerr_pkg::slots_t  slots,
    output kerr_pkg::report_t rep
);

    logic [kerr_pkg::CHAR_CNT_W-1:0] n;
    logic [kerr_pkg::CODE_W-1:0]     c;
    logic [kerr_pkg::CHAR_W-1:0]     ch;

    always_comb
    begin
        rep = '0;
        n   = '0;
        c   = '0;
        ch  = '0;

        for (int i = 0; i < kerr_pkg::SLOT_COUNT; i++)
        begin
            if ((slots[i] == kerr_pkg::K_FN) || (slots[i] == kerr_pkg::K_SHIFT))
            begin
                rep.fn_layer = 1'b1;
            end
            if (slots[i] != '0)
            begin
                rep.any_held = 1'b1;
            end
        end

        for (int i = 0; i < kerr_pkg::SLOT_COUNT; i++)
        begin
            c  = slots[i];
            ch = kerr_pkg::key_char(rep.fn_layer, c);
            if ((c != '0) && !kerr_pkg::is_modifier(c) && (ch != '0) &&
                (n < kerr_pkg::CHAR_CNT_W'(kerr_pkg::OUT_CHARS)))
            begin
                rep.chars[n[kerr_pkg::OUT_IDX_W-1:0]] = ch;
                n = n + kerr_pkg::CHAR_CNT_W'(1);
            end
        end
    end

endmodule

// ----- rtl/core/key_event_rollover_report.sv -----
// Six-key rollover keypad report: top level.
// Path from request accept to report valid: event register, then report register.
// One request per cycle unless the report output stalls; the slot table is read and written in the same cycle.
// Reset (rst_n, asynchronous, active low) empties all six slots and drops both valid flags.
// Depends on kerr_pkg, kerr_if, kerr_slot_update and kerr_report.

module key_event_rollover_report
(
    input  logic                 clk,
    input  logic                 rst_n,
    kerr_event_if.sink           key_event,
    kerr_report_if.source        report
);

    // Event stage
    logic                         ev_valid_reg;
    logic [kerr_pkg::EVENT_W-1:0] ev_reg;

    // Held-key slot table
    kerr_pkg::slots_t             slots_reg;

    // Report stage
    logic                         out_valid_reg;
    logic                         changed_reg;
    kerr_pkg::report_t            rep_reg;

    kerr_pkg::slot_upd_t          upd;
    kerr_pkg::report_t            rep_next;
    logic                         out_free;

    // Report register can take a new request when empty or being drained.
    assign out_free        = !out_valid_reg || report.ready;
    assign key_event.ready = !ev_valid_reg || out_free;

    kerr_slot_update u_slot_update
    (
        .event_byte (ev_reg),
        .slots      (slots_reg),
        .upd        (upd)
    );

    // The report reflects the table after this event has been applied.
    kerr_report u_report
    (
        .slots (upd.slots),
        .rep   (rep_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            slots_reg     <= '0;
        end
        else
        begin
            if (key_event.ready)
            begin
                ev_valid_reg <= key_event.valid;
            end
            if (out_free)
            begin
                out_valid_reg <= ev_valid_reg;
                if (ev_valid_reg)
                begin
                    slots_reg <= upd.slots;
                end
            end
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (key_event.ready && key_event.valid)
        begin
            ev_reg <= key_event.event_byte;
        end
        if (out_free && ev_valid_reg)
        begin
            rep_reg     <= rep_next;
            changed_reg <= upd.changed;
        end
    end

    assign report.valid    = out_valid_reg;
    assign report.fn_layer = rep_reg.fn_layer;
    assign report.char_0   = rep_reg.chars[0];
    assign report.char_1   = rep_reg.chars[1];
    assign report.char_2   = rep_reg.chars[2];
    assign report.char_3   = rep_reg.chars[3];
    assign report.char_4   = rep_reg.chars[4];
    assign report.char_5   = rep_reg.chars[5];
    assign report.any_held = rep_reg.any_held;
    assign report.changed  = changed_reg;

    // A discarded code must leave the slot table untouched.
    a_discard_keeps_slots: assert property (@(posedge clk) disable iff (!rst_n)
        (ev_valid_reg && out_free && !upd.changed) |=> $stable(slots_reg))
        else $error("slot table changed on a discarded event");

    // A pending report always matches the current table occupancy.
    a_any_held_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (report.any_held == (slots_reg != '0)))
        else $error("any_held disagrees with slot table");

    // Input back-pressure only when both stages are full and the report is not taken.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !key_event.ready |-> (ev_valid_reg && out_valid_reg && !report.ready))
        else $error("request refused while a stage was free");

endmodule
